### sv/keyframe_path_interpolator_defines.svh
// Assertion macros for the keyframe path interpolator checker.
// Depends on nothing; included by the checker file only.
`ifndef KEYFRAME_PATH_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_PATH_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication
`define KPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpi check failed");

// Next-cycle implication
`define KPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpi check failed");

`endif

### sv/kpi_pkg.sv
// Shared types and constants of the keyframe path interpolator.
// Used by the top level, the divider and the checker.
package kpi_pkg;

    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 168;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_ADVANCE = 3'd1,
        ACT_EVAL    = 3'd2,
        ACT_SET     = 3'd3,
        ACT_JUMP    = 3'd4,
        ACT_RESTART = 3'd5
    } action_t;

    localparam logic [1:0] MODE_REVERSE = 2'd1;
    localparam logic [1:0] MODE_LOOP    = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_PLAY  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JUMP,
        ST_TCHK,
        ST_MOD,
        ST_WINIT,
        ST_WSTEP,
        ST_WCMP,
        ST_FIN,
        ST_RC,
        ST_RN,
        ST_PCALC,
        ST_PDIV,
        ST_LERP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } key_t;

    typedef struct packed {
        logic        start;
        logic [31:0] init_rem;
        logic [32:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
        logic [15:0] quot;
    } div_rsp_t;

endpackage

### sv/kpi_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on kpi_pkg for its request and response structs.
module kpi_div (
    input  logic             clk,
    input  logic             rst_n,
    input  kpi_pkg::div_req_t req,
    output kpi_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] dvd_reg, dvd_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [15:0] quot_reg, quot_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[32]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.init_rem;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[31:0] : trial[31:0];
            dvd_next  = {dvd_reg[31:0], 1'b0};
            quot_next = {quot_reg[14:0], ge};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.quot = quot_reg;

endmodule

### sv/keyframe_path_interpolator.sv
// Keyframe path interpolator: keyframe table in one synchronous memory. Depends on kpi_pkg, kpi_div.
// Load, set, restart and a paused or non-loop advance finish in the idle state. Jump reads the
// node's time; a loop advance reads the last time and, on a wrap, runs a 33-step modulo in kpi_div.
// Evaluate may wrap likewise, walks from the reached node, divides for the progress unless it is
// clamped, then interpolates x, y, z, yaw and pitch. Input waits until the previous word is done.
// Reset clears config, elapsed time, reached index and output valid; the table is not cleared.
module keyframe_path_interpolator #(
    parameter int MAX_NODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node_index, pos_x, pos_y, pos_z, yaw_angle, pitch_angle, time_value
    input  logic [kpi_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x, out_y, out_z, out_yaw, out_pitch, out_time, reached_node
    output logic [kpi_pkg::M_DATA_W-1:0]  m_tdata,
    // path_empty
    output logic [0:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [6:0]                    cfg_data
);

    localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NLIM = (MAX_NODES < 64) ? MAX_NODES : 64;

    kpi_pkg::key_t mem [MAX_NODES];
    kpi_pkg::key_t rd_data_reg;
    kpi_pkg::key_t wr_data;
    kpi_pkg::key_t kc_reg, kc_next;
    kpi_pkg::key_t kn_reg, kn_next;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    kpi_pkg::state_t  state_reg, state_next;
    kpi_pkg::div_req_t div_req;
    kpi_pkg::div_rsp_t div_rsp;

    logic [1:0]  mode_reg;
    logic [6:0]  count_reg;
    logic        play_reg;
    logic [6:0]  n_eff;
    logic [5:0]  last_idx;
    logic        is_loop, is_rev;

    logic [31:0] elapsed_reg, elapsed_next;
    logic [5:0]  reached_reg, reached_next;
    logic [2:0]  act_reg, act_next;
    logic [32:0] sum_reg, sum_next;
    logic [31:0] last_reg, last_next;
    logic [5:0]  sel_reg, sel_next;
    logic [5:0]  nx_reg, nx_next;
    logic [5:0]  rn_reg, rn_next;
    logic [6:0]  k_reg, k_next;
    logic [16:0] p_reg, p_next;
    logic [2:0]  lane_reg, lane_next;
    logic [31:0] rx_reg, rx_next, ry_reg, ry_next, rz_reg, rz_next;
    logic [15:0] ryaw_reg, ryaw_next, rpitch_reg, rpitch_next;
    logic        rempty_reg, rempty_next;
    logic        mvalid_reg, mvalid_next;
    logic [kpi_pkg::M_DATA_W-1:0] mdata_reg, mdata_next;
    logic        muser_reg, muser_next;

    logic [5:0]  in_idx;
    logic [31:0] in_tv;
    logic [32:0] sum_in;
    logic [31:0] tkey;
    logic [6:0]  nx1;
    logic [6:0]  nxw;
    logic [6:0]  rc7;
    logic [6:0]  rn7;
    logic signed [33:0] nt;
    logic signed [34:0] nd, dt;
    logic [34:0] an, ad;
    logic signed [32:0] ld;
    logic signed [17:0] pe;
    logic signed [50:0] prod;
    logic signed [50:0] sh;
    logic [31:0] lc;
    logic [31:0] lr;
    logic [15:0] dw;

    assign in_idx  = s_tdata[5:0];
    assign in_tv   = s_tdata[165:134];
    assign wr_data = '{t: s_tdata[165:134], pitch: s_tdata[133:118], yaw: s_tdata[117:102],
                       z: s_tdata[101:70], y: s_tdata[69:38], x: s_tdata[37:6]};

    assign n_eff    = (count_reg > 7'(NLIM)) ? 7'(NLIM) : count_reg;
    assign last_idx = 6'(n_eff - 7'd1);
    assign is_loop  = (mode_reg == kpi_pkg::MODE_LOOP);
    assign is_rev   = (mode_reg == kpi_pkg::MODE_REVERSE);
    assign s_tready = (state_reg == kpi_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    kpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        reached_next = reached_reg;
        act_next     = act_reg;
        sum_next     = sum_reg;
        last_next    = last_reg;
        sel_next     = sel_reg;
        nx_next      = nx_reg;
        rn_next      = rn_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        lane_next    = lane_reg;
        kc_next      = kc_reg;
        kn_next      = kn_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        rz_next      = rz_reg;
        ryaw_next    = ryaw_reg;
        rpitch_next  = rpitch_reg;
        rempty_next  = rempty_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        mem_we       = 1'b0;
        rd_addr      = AW'(sel_reg);
        div_req      = '0;
        sum_in       = {1'b0, elapsed_reg} + {1'b0, in_tv};
        tkey         = rd_data_reg.t;
        nx1          = {1'b0, sel_reg} + 7'd1;
        nxw          = (nx1 == n_eff) ? 7'd0 : nx1;
        rc7          = '0;
        rn7          = '0;
        nt           = is_rev ? ($signed({2'b0, last_reg}) - $signed({2'b0, tkey}))
                              : $signed({2'b0, tkey});
        if (is_rev)
        begin
            nd = $signed({3'b0, kc_reg.t}) - $signed({3'b0, kn_reg.t});
            dt = $signed({3'b0, kc_reg.t}) - $signed({3'b0, last_reg})
                 + $signed({3'b0, elapsed_reg});
        end
        else
        begin
            nd = $signed({3'b0, kn_reg.t}) - $signed({3'b0, kc_reg.t});
            dt = $signed({3'b0, elapsed_reg}) - $signed({3'b0, kc_reg.t});
        end
        an = nd[34] ? 35'(-nd) : 35'(nd);
        ad = dt[34] ? 35'(-dt) : 35'(dt);
        dw = 16'd0;
        case (lane_reg)
            3'd0:
            begin
                lc = kc_reg.x;
                ld = $signed({kn_reg.x[31], kn_reg.x}) - $signed({kc_reg.x[31], kc_reg.x});
            end
            3'd1:
            begin
                lc = kc_reg.y;
                ld = $signed({kn_reg.y[31], kn_reg.y}) - $signed({kc_reg.y[31], kc_reg.y});
            end
            3'd2:
            begin
                lc = kc_reg.z;
                ld = $signed({kn_reg.z[31], kn_reg.z}) - $signed({kc_reg.z[31], kc_reg.z});
            end
            3'd3:
            begin
                lc = {16'd0, kc_reg.yaw};
                dw = kn_reg.yaw - kc_reg.yaw;
                ld = $signed({{17{dw[15]}}, dw});
            end
            default:
            begin
                lc = {16'd0, kc_reg.pitch};
                dw = kn_reg.pitch - kc_reg.pitch;
                ld = $signed({{17{dw[15]}}, dw});
            end
        endcase
        pe   = $signed({1'b0, p_reg});
        prod = ld * pe;
        sh   = prod >>> 16;
        lr   = lc + sh[31:0];

        case (state_reg)
            kpi_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next = s_tuser;
                    case (s_tuser)
                        kpi_pkg::ACT_LOAD:
                        begin
                            if (32'(in_idx) < MAX_NODES)
                                mem_we = 1'b1;
                        end
                        kpi_pkg::ACT_ADVANCE:
                        begin
                            if (play_reg)
                            begin
                                if (is_loop && n_eff != 7'd0)
                                begin
                                    sum_next   = sum_in;
                                    rd_addr    = AW'(last_idx);
                                    state_next = kpi_pkg::ST_TCHK;
                                end
                                else
                                    elapsed_next = sum_in[32] ? 32'hFFFF_FFFF : sum_in[31:0];
                            end
                        end
                        kpi_pkg::ACT_EVAL:
                        begin
                            if (n_eff == 7'd0)
                            begin
                                rx_next     = '0;
                                ry_next     = '0;
                                rz_next     = '0;
                                ryaw_next   = '0;
                                rpitch_next = '0;
                                rempty_next = 1'b1;
                                state_next  = kpi_pkg::ST_OUT;
                            end
                            else
                            begin
                                rd_addr    = AW'(last_idx);
                                state_next = kpi_pkg::ST_TCHK;
                            end
                        end
                        kpi_pkg::ACT_SET:
                            elapsed_next = in_tv;
                        kpi_pkg::ACT_JUMP:
                        begin
                            if (n_eff != 7'd0)
                            begin
                                rd_addr    = AW'((in_idx > last_idx) ? last_idx : in_idx);
                                state_next = kpi_pkg::ST_JUMP;
                            end
                        end
                        kpi_pkg::ACT_RESTART:
                        begin
                            elapsed_next = '0;
                            reached_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            kpi_pkg::ST_JUMP:
            begin
                elapsed_next = tkey;
                state_next   = kpi_pkg::ST_IDLE;
            end
            kpi_pkg::ST_TCHK:
            begin
                last_next = tkey;
                if (act_reg == kpi_pkg::ACT_ADVANCE)
                begin
                    if (sum_reg >= {1'b0, tkey})
                    begin
                        if (tkey == 32'd0)
                        begin
                            elapsed_next = '0;
                            reached_next = '0;
                            state_next   = kpi_pkg::ST_IDLE;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = sum_reg;
                            div_req.divisor  = tkey;
                            div_req.steps    = 6'd33;
                            state_next       = kpi_pkg::ST_MOD;
                        end
                    end
                    else
                    begin
                        elapsed_next = sum_reg[32] ? 32'hFFFF_FFFF : sum_reg[31:0];
                        state_next   = kpi_pkg::ST_IDLE;
                    end
                end
                else if (play_reg && is_loop && elapsed_reg >= tkey)
                begin
                    if (tkey == 32'd0)
                    begin
                        elapsed_next = '0;
                        reached_next = '0;
                        state_next   = kpi_pkg::ST_WINIT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {1'b0, elapsed_reg};
                        div_req.divisor  = tkey;
                        div_req.steps    = 6'd33;
                        state_next       = kpi_pkg::ST_MOD;
                    end
                end
                else
                    state_next = kpi_pkg::ST_WINIT;
            end
            kpi_pkg::ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    elapsed_next = div_rsp.rem;
                    reached_next = '0;
                    state_next   = (act_reg == kpi_pkg::ACT_ADVANCE) ? kpi_pkg::ST_IDLE
                                                                     : kpi_pkg::ST_WINIT;
                end
            end
            kpi_pkg::ST_WINIT:
            begin
                sel_next   = ({1'b0, reached_reg} >= n_eff) ? 6'd0 : reached_reg;
                k_next     = '0;
                state_next = kpi_pkg::ST_WSTEP;
            end
            kpi_pkg::ST_WSTEP:
            begin
                if (k_reg >= n_eff || (!is_loop && nx1 >= n_eff))
                    state_next = kpi_pkg::ST_FIN;
                else
                begin
                    rn7        = is_loop ? nxw : nx1;
                    nx_next    = 6'(rn7);
                    rc7        = is_rev ? (n_eff - 7'd1 - rn7) : rn7;
                    rd_addr    = AW'(rc7);
                    state_next = kpi_pkg::ST_WCMP;
                end
            end
            kpi_pkg::ST_WCMP:
            begin
                if (nt <= $signed({2'b0, elapsed_reg}))
                begin
                    sel_next   = nx_reg;
                    k_next     = k_reg + 7'd1;
                    state_next = kpi_pkg::ST_WSTEP;
                end
                else
                    state_next = kpi_pkg::ST_FIN;
            end
            kpi_pkg::ST_FIN:
            begin
                reached_next = sel_reg;
                if (is_loop)
                    nx_next = 6'(nxw);
                else
                    nx_next = (nx1 >= n_eff) ? sel_reg : 6'(nx1);
                rc7        = is_rev ? (n_eff - 7'd1 - {1'b0, sel_reg}) : {1'b0, sel_reg};
                rn7        = is_rev ? (n_eff - 7'd1 - {1'b0, nx_next}) : {1'b0, nx_next};
                rn_next    = 6'(rn7);
                rd_addr    = AW'(rc7);
                state_next = kpi_pkg::ST_RC;
            end
            kpi_pkg::ST_RC:
            begin
                kc_next    = rd_data_reg;
                rd_addr    = AW'(rn_reg);
                state_next = kpi_pkg::ST_RN;
            end
            kpi_pkg::ST_RN:
            begin
                kn_next    = rd_data_reg;
                state_next = kpi_pkg::ST_PCALC;
            end
            kpi_pkg::ST_PCALC:
            begin
                lane_next = '0;
                if ((is_loop && nx_reg == 6'd0) || nd == 35'sd0 || dt == 35'sd0
                    || (nd[34] != dt[34]))
                begin
                    p_next     = '0;
                    state_next = kpi_pkg::ST_LERP;
                end
                else if (ad >= an)
                begin
                    p_next     = 17'h10000;
                    state_next = kpi_pkg::ST_LERP;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.init_rem = ad[31:0];
                    div_req.divisor  = an[31:0];
                    div_req.steps    = 6'd16;
                    state_next       = kpi_pkg::ST_PDIV;
                end
            end
            kpi_pkg::ST_PDIV:
            begin
                if (div_rsp.done)
                begin
                    p_next     = {1'b0, div_rsp.quot};
                    state_next = kpi_pkg::ST_LERP;
                end
            end
            kpi_pkg::ST_LERP:
            begin
                lane_next = lane_reg + 3'd1;
                case (lane_reg)
                    3'd0: rx_next = lr;
                    3'd1: ry_next = lr;
                    3'd2: rz_next = lr;
                    3'd3: ryaw_next = lr[15:0];
                    default:
                    begin
                        rpitch_next = lr[15:0];
                        rempty_next = 1'b0;
                        state_next  = kpi_pkg::ST_OUT;
                    end
                endcase
            end
            kpi_pkg::ST_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {2'b0, reached_reg, elapsed_reg, rpitch_reg, ryaw_reg,
                                   rz_reg, ry_reg, rx_reg};
                    muser_next  = rempty_reg;
                    state_next  = kpi_pkg::ST_IDLE;
                end
            end
            default:
                state_next = kpi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AW'(in_idx)] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            count_reg <= '0;
            play_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                kpi_pkg::CFG_MODE:  mode_reg  <= cfg_data[1:0];
                kpi_pkg::CFG_COUNT: count_reg <= cfg_data;
                kpi_pkg::CFG_PLAY:  play_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kpi_pkg::ST_IDLE;
            elapsed_reg <= '0;
            reached_reg <= '0;
            mvalid_reg  <= 1'b0;
            act_reg     <= '0;
            lane_reg    <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            reached_reg <= reached_next;
            mvalid_reg  <= mvalid_next;
            act_reg     <= act_next;
            lane_reg    <= lane_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        last_reg   <= last_next;
        sel_reg    <= sel_next;
        nx_reg     <= nx_next;
        rn_reg     <= rn_next;
        p_reg      <= p_next;
        kc_reg     <= kc_next;
        kn_reg     <= kn_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        rz_reg     <= rz_next;
        ryaw_reg   <= ryaw_next;
        rpitch_reg <= rpitch_next;
        rempty_reg <= rempty_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

endmodule

### sv/kpi_checker.sv
// Port-level checks of the keyframe path interpolator, bound to the top level.
// Depends on kpi_pkg and keyframe_path_interpolator_defines.svh.
`include "keyframe_path_interpolator_defines.svh"

module kpi_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [2:0]                   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [kpi_pkg::M_DATA_W-1:0] m_tdata,
    input logic [0:0]                   m_tuser
);

    `KPI_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `KPI_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `KPI_ASSERT_NOW(a_empty_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata[127:0] == 128'd0)
    `KPI_ASSERT_NEXT(a_load_quiet, clk, rst_n, s_tvalid && s_tready && s_tuser == kpi_pkg::ACT_LOAD, !$rose(m_tvalid))

endmodule

bind keyframe_path_interpolator kpi_checker u_kpi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
